// File: rtl/nsdq_pkg.sv
// Shared types, constants and functions of the noise-shaped dither quantizer.
// No dependencies; every other file imports this package.
package nsdq_pkg;

  localparam int unsigned DATA_W = 32;

  // Linear congruential noise generator
  localparam logic [DATA_W-1:0] LCG_MUL = 32'h0019_660D;
  localparam logic [DATA_W-1:0] LCG_ADD = 32'h3C6E_F35F;

  // Per-channel state word kept in the state memory
  typedef struct packed {
    logic [DATA_W-1:0] seed_nxt;  // generator output for the next item
    logic [DATA_W-1:0] seed;      // current generator state
    logic [DATA_W-1:0] err_c;     // older error
    logic [DATA_W-1:0] err_b;     // halved previous error
    logic [DATA_W-1:0] err_a;     // newest error
  } state_t;

  // Seed after reset is zero, so its successor is the generator increment
  localparam state_t ST_RESET = '{
    seed_nxt: LCG_ADD,
    seed:     '0,
    err_c:    '0,
    err_b:    '0,
    err_a:    '0
  };

  function automatic logic [DATA_W-1:0] lcg_next(input logic [DATA_W-1:0] s);
    lcg_next = s * LCG_MUL + LCG_ADD;
  endfunction

endpackage

// File: rtl/nsdq_state_mem.sv
// Per-channel state memory with registered read.
// Entries never written read as the reset state through per-entry valid bits.
// Depends on nsdq_pkg.
module nsdq_state_mem
  import nsdq_pkg::*;
#(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output state_t        rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  state_t        wr_data_i
);

  state_t               mem [DEPTH];
  logic   [DEPTH-1:0]   vld_q;
  state_t               rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read before write: a same-edge write is forwarded by the caller
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : ST_RESET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/nsdq_calc.sv
// Per-item arithmetic: noise shaping, dither, clipping, quantization and
// the updated channel state. Purely combinational. Depends on nsdq_pkg.
module nsdq_calc
  import nsdq_pkg::*;
#(
  parameter int unsigned OUT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic [DATA_W-1:0]   sample_i,
  input  state_t              st_i,
  output state_t              st_o,
  output logic [OUT_BITS-1:0] pcm_o
);

  localparam int unsigned       SCALE_BITS = FRAC_BITS + 1 - OUT_BITS;
  localparam logic [DATA_W-1:0] LOW_MASK   = (32'd1 << SCALE_BITS) - 32'd1;
  localparam logic [DATA_W-1:0] BIAS       = 32'd1 << (FRAC_BITS - OUT_BITS);
  localparam logic [DATA_W-1:0] HI         = (32'd1 << FRAC_BITS) - 32'd1;
  localparam logic [DATA_W-1:0] LO         = ~HI;

  logic [DATA_W-1:0] smp;
  logic [DATA_W-1:0] dith;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] s_clip;
  logic [DATA_W-1:0] o_clip;
  logic [DATA_W-1:0] o_quant;
  logic [DATA_W-1:0] a_half;

  always_comb begin
    smp  = sample_i + st_i.err_a - st_i.err_b + st_i.err_c;
    dith = BIAS + (st_i.seed_nxt & LOW_MASK) - (st_i.seed & LOW_MASK);
    acc  = smp + dith;

    s_clip = smp;
    o_clip = acc;
    // Clip the shaped sample only on the side where the output clipped
    if ($signed(acc) > $signed(HI)) begin
      o_clip = HI;
      if ($signed(smp) > $signed(HI)) begin
        s_clip = HI;
      end
    end else if ($signed(acc) < $signed(LO)) begin
      o_clip = LO;
      if ($signed(smp) < $signed(LO)) begin
        s_clip = LO;
      end
    end

    o_quant = o_clip & ~LOW_MASK;

    // Halve toward zero: add one to negative values before the shift
    a_half = DATA_W'($signed(st_i.err_a + {{(DATA_W-1){1'b0}}, st_i.err_a[DATA_W-1]}) >>> 1);

    st_o.err_a    = s_clip - o_quant;
    st_o.err_b    = a_half;
    st_o.err_c    = st_i.err_b;
    st_o.seed     = st_i.seed_nxt;
    st_o.seed_nxt = lcg_next(st_i.seed_nxt);

    pcm_o = o_quant[SCALE_BITS +: OUT_BITS];
  end

endmodule

// File: rtl/noise_shaped_dither_quantizer.sv
// Noise-shaped triangular dither requantizer, top level.
// An accepted item passes the input stage, then the output register; throughput is
// one item per cycle while the output is taken, also for the same channel back to back;
// the state memory read is issued at accept and a same-edge write is forwarded.
// Reset clears the control state and the per-channel valid bits at once.
// Depends on nsdq_pkg, nsdq_state_mem and nsdq_calc.
module noise_shaped_dither_quantizer
  import nsdq_pkg::*;
#(
  parameter int unsigned OUT_BITS     = 16,
  parameter int unsigned FRAC_BITS    = 28,
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [DATA_W-1:0]               s_axis_tdata,  // [31:0] sample_in
  input  logic                            s_axis_tuser,  // [0] channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [((OUT_BITS+7)/8)*8-1:0]   m_axis_tdata   // [OUT_BITS-1:0] pcm_out
);

  localparam int unsigned AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  logic                in_acc;
  logic [AW-1:0]       in_ch;
  logic                out_free;
  logic                s1_adv;

  logic                s1_vld_q, s1_vld_d;
  logic [AW-1:0]       s1_ch_q;
  logic [DATA_W-1:0]   s1_smp_q;
  logic                fwd_q, fwd_d;
  state_t              fwd_st_q;
  logic                out_vld_q, out_vld_d;
  logic [OUT_BITS-1:0] out_pcm_q;

  state_t              rd_st;
  state_t              cur_st;
  state_t              new_st;
  logic [OUT_BITS-1:0] pcm;

  assign in_ch    = (NUM_CHANNELS > 1) ? AW'(s_axis_tuser) : '0;
  assign out_free = !out_vld_q || m_axis_tready;
  assign s1_adv   = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  nsdq_state_mem #(
    .DEPTH (NUM_CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_ch),
    .rd_data_o (rd_st),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_ch_q),
    .wr_data_i (new_st)
  );

  // Take the state written on the accept edge when the channel matches
  assign cur_st = fwd_q ? fwd_st_q : rd_st;

  nsdq_calc #(
    .OUT_BITS  (OUT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_calc (
    .sample_i (s1_smp_q),
    .st_i     (cur_st),
    .st_o     (new_st),
    .pcm_o    (pcm)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    fwd_d    = fwd_q;
    if (in_acc) begin
      s1_vld_d = 1'b1;
      fwd_d    = s1_adv && (s1_ch_q == in_ch);
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    if (s1_adv) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      fwd_q     <= fwd_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q  <= in_ch;
      s1_smp_q <= s_axis_tdata;
      fwd_st_q <= new_st;
    end
    if (s1_adv) begin
      out_pcm_q <= pcm;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDATA_W'(out_pcm_q);

endmodule

// File: rtl/nsdq_checker.sv
// Port-level checks of the quantizer: item bookkeeping, readiness, known inputs and stalls.
// Bound to noise_shaped_dither_quantizer; depends on nsdq_pkg.
module nsdq_checker
  import nsdq_pkg::*;
#(
  parameter int unsigned OUT_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [DATA_W-1:0]             s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [((OUT_BITS+7)/8)*8-1:0] m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] occ_q, occ_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Items accepted but not yet delivered
  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      occ_d = occ_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (occ_q != 3'd0))
    else $error("result shown with no item in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'd2)
    else $error("more items in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == 3'd0) |-> s_axis_tready)
    else $error("empty block refuses an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown({s_axis_tdata, s_axis_tuser}))
    else $error("offered item carries unknown bits");

endmodule

bind noise_shaped_dither_quantizer nsdq_checker #(
  .OUT_BITS (OUT_BITS)
) u_nsdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
